FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the pose filter.
// Each macro expects clk and arst_n in scope of the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/poge_pkg.sv
// Package of the outlier-gated pose filter: payload and config types,
// register indexes, reset values and default queue depths. No dependencies.
`default_nettype none

package poge_pkg;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam int DEF_IN_DEPTH  = 4;
	localparam int DEF_OUT_DEPTH = 2;

	// Config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POSITION_GATE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_GATE      = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AGREE_NEEDED  = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAND_POS_TOL  = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAND_YAW_TOL  = 8'd5;

	// Config reset values
	localparam logic [15:0] RST_BLEND_WEIGHT  = 16'd9830;
	localparam logic [30:0] RST_POSITION_GATE = 31'd26214;
	localparam logic [15:0] RST_YAW_GATE      = 16'd5215;
	localparam logic [7:0]  RST_AGREE_NEEDED  = 8'd5;
	localparam logic [30:0] RST_CAND_POS_TOL  = 31'd9830;
	localparam logic [15:0] RST_CAND_YAW_TOL  = 16'd2086;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	typedef enum logic [1:0] {
		OUT_LOCK    = 2'd0,
		OUT_FILTER  = 2'd1,
		OUT_PENDING = 2'd2,
		OUT_RELOC   = 2'd3
	} outcome_t;

	typedef struct packed {
		logic signed [31:0] meas_x;
		logic signed [31:0] meas_y;
		logic [15:0]        meas_heading;
	} meas_t;

	typedef struct packed {
		outcome_t           outcome;
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic [15:0]        pose_yaw;
		logic [7:0]         pending_count;
	} result_t;

	typedef struct packed {
		logic [15:0] blend_weight;
		logic [30:0] position_gate;
		logic [15:0] yaw_gate;
		logic [7:0]  agree_count_needed;
		logic [30:0] candidate_position_tolerance;
		logic [15:0] candidate_yaw_tolerance;
	} cfg_t;

endpackage

`default_nettype wire

FILE: rtl/pose_outlier_gated_ema_filter.sv
// Outlier-gated EMA pose filter, top level.
// Channels: requests enter by push/full, results leave by empty/pop, both
// carried as packed structs; config registers are written through
// cfg_valid/cfg_ready with cfg_index and cfg_data (cfg_ready is always high,
// an index past the last register is dropped).
// A pushed request is taken from the input FIFO once the engine is free and the
// output FIFO has room; its result shows on result (empty low) once written.
// No new request is taken before the last is through the engine's state loop:
// differences, then squares and blend products, then compare and update of
// the smoothed pose that the next request is measured against.
// Requests queue in an input FIFO of IN_DEPTH entries, results in an output
// FIFO of OUT_DEPTH entries; a stalled pop fills the output FIFO, then the
// engine holds, then full rises once the input FIFO fills.
// Reset clears both queues, unlocks the filter, zeroes the candidate count
// and loads the default register values; the first request then locks the pose.
// Uses poge_pkg, poge_fifo, poge_core and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module pose_outlier_gated_ema_filter #(
	parameter int IN_DEPTH  = poge_pkg::DEF_IN_DEPTH,
	parameter int OUT_DEPTH = poge_pkg::DEF_OUT_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  poge_pkg::meas_t                     item,
	output logic                                empty,
	input  logic                                pop,
	output poge_pkg::result_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [poge_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [poge_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import poge_pkg::*;

	localparam int MEAS_W = $bits(meas_t);
	localparam int RES_W  = $bits(result_t);

	cfg_t              cfg_q;
	logic [MEAS_W-1:0] head_vec;
	logic [RES_W-1:0]  out_vec;
	meas_t             head;
	result_t           core_res;
	logic              in_empty, item_take, res_push, out_full;

	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blend_weight                 <= RST_BLEND_WEIGHT;
			cfg_q.position_gate                <= RST_POSITION_GATE;
			cfg_q.yaw_gate                     <= RST_YAW_GATE;
			cfg_q.agree_count_needed           <= RST_AGREE_NEEDED;
			cfg_q.candidate_position_tolerance <= RST_CAND_POS_TOL;
			cfg_q.candidate_yaw_tolerance      <= RST_CAND_YAW_TOL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BLEND_WEIGHT:  cfg_q.blend_weight <= cfg_data[15:0];
				REG_POSITION_GATE: cfg_q.position_gate <= cfg_data[30:0];
				REG_YAW_GATE:      cfg_q.yaw_gate <= cfg_data[15:0];
				REG_AGREE_NEEDED:  cfg_q.agree_count_needed <= cfg_data[7:0];
				REG_CAND_POS_TOL:  cfg_q.candidate_position_tolerance <= cfg_data[30:0];
				REG_CAND_YAW_TOL:  cfg_q.candidate_yaw_tolerance <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// front: request queue
	poge_fifo #(
		.DEPTH (IN_DEPTH),
		.W     (MEAS_W)
	) u_in_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (item),
		.full    (full),
		.rd_en   (item_take),
		.rd_data (head_vec),
		.empty   (in_empty)
	);

	assign head = meas_t'(head_vec);

	// back: filter engine
	poge_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req       (head),
		.req_avail (!in_empty),
		.req_take  (item_take),
		.res       (core_res),
		.res_push  (res_push),
		.res_room  (!out_full)
	);

	// result queue
	poge_fifo #(
		.DEPTH (OUT_DEPTH),
		.W     (RES_W)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (core_res),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (out_vec),
		.empty   (empty)
	);

	assign result = result_t'(out_vec);

	// checks
	`ASSERT_IMPLY(a_push_room, res_push, !out_full, "result pushed into a full queue")
	`ASSERT_IMPLY(a_take_avail, item_take, !in_empty, "engine took from an empty queue")
	`ASSERT_NEXT(a_push_spacing, res_push, !res_push, "two results in consecutive cycles")
	`ASSERT_IMPLY(a_pending_count, res_push && (core_res.outcome == OUT_PENDING),
		core_res.pending_count != 8'd0, "pending result with zero candidate count")

endmodule

`default_nettype wire

FILE: rtl/poge_fifo.sv
// Small register queue used on both sides of the pose filter engine.
// Self-contained; width and depth come from parameters.
`default_nettype none

module poge_fifo #(
	parameter int DEPTH = 2,
	parameter int W     = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/poge_core.sv
// Filter engine: three-step sequence per request (differences, products,
// decide and update) around the smoothed-pose and candidate state. Uses poge_pkg.
`default_nettype none

module poge_core (
	input  logic              clk,
	input  logic              arst_n,
	input  poge_pkg::cfg_t    cfg,
	input  poge_pkg::meas_t   req,
	input  logic              req_avail,
	output logic              req_take,
	output poge_pkg::result_t res,
	output logic              res_push,
	input  logic              res_room
);
	import poge_pkg::*;

	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_MUL  = 3'b010,
		ST_UPD  = 3'b100
	} eng_state_t;

	function automatic logic [31:0] abs_pos(input logic signed [32:0] v);
		logic signed [32:0] n;
		n = -v;
		return v[32] ? n[31:0] : v[31:0];
	endfunction

	function automatic logic [15:0] abs_yaw(input logic signed [15:0] v);
		logic signed [15:0] n;
		n = -v;
		return v[15] ? n : v;
	endfunction

	eng_state_t st_q;

	// filter state
	logic               locked_q;
	logic signed [31:0] smooth_x_q, smooth_y_q, cand_x_q, cand_y_q;
	logic [15:0]        smooth_yaw_q, cand_yaw_q;
	logic [7:0]         cand_count_q;

	// step 1: differences against smoothed pose and candidate
	logic signed [32:0] dsx, dsy, dcx, dcy;
	logic signed [15:0] dsyaw, dcyaw;

	logic signed [31:0] mx_s1, my_s1;
	logic [15:0]        myaw_s1;
	logic signed [32:0] dsx_s1, dsy_s1, dcx_s1, dcy_s1;
	logic signed [15:0] dsyaw_s1, dcyaw_s1;
	logic [31:0]        ax_s1, ay_s1, cax_s1, cay_s1;
	logic [15:0]        ayaw_s1, acyaw_s1;

	// step 2: squares and EMA products
	logic [63:0]        sqx_s2, sqy_s2, csqx_s2, csqy_s2;
	logic [61:0]        gate_sq_s2, tol_sq_s2;
	logic signed [49:0] prx_s2, pry_s2;
	logic signed [32:0] pryaw_s2;

	// step 3: decision and next state
	logic [64:0]        dist_sq, cdist_sq;
	logic               outlier, agree, reloc;
	logic [7:0]         cnt_inc;
	logic signed [49:0] rnd_x, rnd_y;
	logic signed [32:0] rnd_yaw;
	logic signed [31:0] ema_x, ema_y, avg_x, avg_y;
	logic [15:0]        ema_yaw, avg_yaw;
	logic [33:0]        half_x, half_y;
	logic [16:0]        half_yaw;

	logic               nx_locked;
	logic signed [31:0] nx_sx, nx_sy, nx_cx, nx_cy;
	logic [15:0]        nx_syaw, nx_cyaw;
	logic [7:0]         nx_count;
	outcome_t           nx_outcome;

	assign req_take = (st_q == ST_LOAD) && req_avail && res_room;
	assign res_push = (st_q == ST_UPD);

	assign dsx   = {req.meas_x[31], req.meas_x} - {smooth_x_q[31], smooth_x_q};
	assign dsy   = {req.meas_y[31], req.meas_y} - {smooth_y_q[31], smooth_y_q};
	assign dcx   = {req.meas_x[31], req.meas_x} - {cand_x_q[31], cand_x_q};
	assign dcy   = {req.meas_y[31], req.meas_y} - {cand_y_q[31], cand_y_q};
	assign dsyaw = req.meas_heading - smooth_yaw_q;
	assign dcyaw = req.meas_heading - cand_yaw_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
		end else begin
			case (st_q)
				ST_LOAD: begin
					if (req_take) st_q <= ST_MUL;
				end
				ST_MUL:  st_q <= ST_UPD;
				ST_UPD:  st_q <= ST_LOAD;
				default: st_q <= ST_LOAD;
			endcase
		end
	end

	// step 1 registers
	always_ff @(posedge clk) begin
		if (req_take) begin
			mx_s1    <= req.meas_x;
			my_s1    <= req.meas_y;
			myaw_s1  <= req.meas_heading;
			dsx_s1   <= dsx;
			dsy_s1   <= dsy;
			dcx_s1   <= dcx;
			dcy_s1   <= dcy;
			dsyaw_s1 <= dsyaw;
			dcyaw_s1 <= dcyaw;
			ax_s1    <= abs_pos(dsx);
			ay_s1    <= abs_pos(dsy);
			cax_s1   <= abs_pos(dcx);
			cay_s1   <= abs_pos(dcy);
			ayaw_s1  <= abs_yaw(dsyaw);
			acyaw_s1 <= abs_yaw(dcyaw);
		end
	end

	// step 2 registers: one multiply per path
	always_ff @(posedge clk) begin
		if (st_q == ST_MUL) begin
			sqx_s2     <= {32'd0, ax_s1} * {32'd0, ax_s1};
			sqy_s2     <= {32'd0, ay_s1} * {32'd0, ay_s1};
			csqx_s2    <= {32'd0, cax_s1} * {32'd0, cax_s1};
			csqy_s2    <= {32'd0, cay_s1} * {32'd0, cay_s1};
			gate_sq_s2 <= {31'd0, cfg.position_gate} * {31'd0, cfg.position_gate};
			tol_sq_s2  <= {31'd0, cfg.candidate_position_tolerance}
				* {31'd0, cfg.candidate_position_tolerance};
			prx_s2     <= 50'(dsx_s1) * 50'($signed({1'b0, cfg.blend_weight}));
			pry_s2     <= 50'(dsy_s1) * 50'($signed({1'b0, cfg.blend_weight}));
			pryaw_s2   <= 33'(dsyaw_s1) * 33'($signed({1'b0, cfg.blend_weight}));
		end
	end

	// gate and agreement tests on exact squared norms
	assign dist_sq  = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign cdist_sq = {1'b0, csqx_s2} + {1'b0, csqy_s2};
	assign outlier  = (dist_sq > {3'd0, gate_sq_s2}) || (ayaw_s1 > cfg.yaw_gate);
	assign agree    = (cand_count_q != '0) && (cdist_sq < {3'd0, tol_sq_s2})
		&& (acyaw_s1 < cfg.candidate_yaw_tolerance);
	assign cnt_inc  = !agree ? 8'd1 :
		(cand_count_q == COUNT_MAX) ? COUNT_MAX : cand_count_q + 8'd1;
	assign reloc    = (cnt_inc >= cfg.agree_count_needed);

	// EMA blend, rounding half up; the sum stays between ref and meas
	assign rnd_x   = prx_s2 + 50'sd32768;
	assign rnd_y   = pry_s2 + 50'sd32768;
	assign rnd_yaw = pryaw_s2 + 33'sd32768;
	assign ema_x   = smooth_x_q + rnd_x[47:16];
	assign ema_y   = smooth_y_q + rnd_y[47:16];
	assign ema_yaw = smooth_yaw_q + rnd_yaw[31:16];

	// candidate midpoint: ref + floor((d + 1) / 2)
	assign half_x   = {dcx_s1[32], dcx_s1} + 34'd1;
	assign half_y   = {dcy_s1[32], dcy_s1} + 34'd1;
	assign half_yaw = {dcyaw_s1[15], dcyaw_s1} + 17'd1;
	assign avg_x    = cand_x_q + half_x[32:1];
	assign avg_y    = cand_y_q + half_y[32:1];
	assign avg_yaw  = cand_yaw_q + half_yaw[16:1];

	// next state select
	always_comb begin
		nx_locked  = locked_q;
		nx_sx      = smooth_x_q;
		nx_sy      = smooth_y_q;
		nx_syaw    = smooth_yaw_q;
		nx_cx      = cand_x_q;
		nx_cy      = cand_y_q;
		nx_cyaw    = cand_yaw_q;
		nx_count   = cand_count_q;
		nx_outcome = OUT_FILTER;
		if (!locked_q) begin
			nx_locked  = 1'b1;
			nx_sx      = mx_s1;
			nx_sy      = my_s1;
			nx_syaw    = myaw_s1;
			nx_count   = '0;
			nx_outcome = OUT_LOCK;
		end else if (outlier) begin
			if (agree) begin
				nx_cx   = avg_x;
				nx_cy   = avg_y;
				nx_cyaw = avg_yaw;
			end else begin
				nx_cx   = mx_s1;
				nx_cy   = my_s1;
				nx_cyaw = myaw_s1;
			end
			if (reloc) begin
				nx_sx      = nx_cx;
				nx_sy      = nx_cy;
				nx_syaw    = nx_cyaw;
				nx_count   = '0;
				nx_outcome = OUT_RELOC;
			end else begin
				nx_count   = cnt_inc;
				nx_outcome = OUT_PENDING;
			end
		end else begin
			nx_count   = '0;
			nx_sx      = ema_x;
			nx_sy      = ema_y;
			nx_syaw    = ema_yaw;
			nx_outcome = OUT_FILTER;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q     <= 1'b0;
			cand_count_q <= '0;
		end else if (st_q == ST_UPD) begin
			locked_q     <= nx_locked;
			cand_count_q <= nx_count;
		end
	end

	// pose state
	always_ff @(posedge clk) begin
		if (st_q == ST_UPD) begin
			smooth_x_q   <= nx_sx;
			smooth_y_q   <= nx_sy;
			smooth_yaw_q <= nx_syaw;
			cand_x_q     <= nx_cx;
			cand_y_q     <= nx_cy;
			cand_yaw_q   <= nx_cyaw;
		end
	end

	always_comb begin
		res.outcome       = nx_outcome;
		res.pose_x        = nx_sx;
		res.pose_y        = nx_sy;
		res.pose_yaw      = nx_syaw;
		res.pending_count = nx_count;
	end

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Testbench of the outlier-gated EMA pose filter: a directed table, then random
// phases under changing register settings, checked by table or local predictor.
// Depends on poge_pkg and pose_outlier_gated_ema_filter.
module tb;
	import poge_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 12;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 100;
	localparam int MAX_GAP       = 13;
	localparam int SETTLE_CYCLES = 12;
	localparam longint POS_MIN   = -64'sd2147483648;
	localparam longint POS_MAX   = 64'sd2147483647;

	// Register settings of the first phases; later phases are random
	localparam int PH_WIDE        = 1;
	localparam int PH_NARROW      = 2;
	localparam int PH_LONG_STREAK = 3;

	// What a stimulus offset is measured from
	typedef enum logic [1:0] {AT_ABS, AT_POSE, AT_CAND} anchor_t;

	typedef struct {
		anchor_t  anchor;
		longint   dx;
		longint   dy;
		int       dyaw;
		bit       checked;
		outcome_t outcome;
		longint   x;
		longint   y;
		int       yaw;
		int       count;
	} dir_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	logic                  full;
	meas_t                 item      = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	result_t               result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Predictor state
	cfg_t               filt_cfg;
	bit                 pose_locked;
	logic signed [31:0] pose_x, pose_y, cand_x, cand_y;
	logic [15:0]        pose_yaw, cand_yaw;
	logic [7:0]         cand_n;

	result_t  pose_reports_due[$];
	dir_row_t dir_rows[$];
	int       errors = 0;
	int       cycles = 0;
	bit       tx_idle = 1'b1;
	bit       rx_idle = 1'b1;
	int       streak_left = 0;
	bit       full_cluster_due = 1'b0;

	pose_outlier_gated_ema_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ---------------- predictor ----------------

	function automatic void filter_reset();
		filt_cfg.blend_weight                 = RST_BLEND_WEIGHT;
		filt_cfg.position_gate                = RST_POSITION_GATE;
		filt_cfg.yaw_gate                     = RST_YAW_GATE;
		filt_cfg.agree_count_needed           = RST_AGREE_NEEDED;
		filt_cfg.candidate_position_tolerance = RST_CAND_POS_TOL;
		filt_cfg.candidate_yaw_tolerance      = RST_CAND_YAW_TOL;
		pose_locked = 1'b0;
		pose_x = '0;
		pose_y = '0;
		pose_yaw = '0;
		cand_x = '0;
		cand_y = '0;
		cand_yaw = '0;
		cand_n = '0;
	endfunction

	// Only the low bits of each register survive; unknown indexes are dropped
	function automatic void filter_config(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_BLEND_WEIGHT:  filt_cfg.blend_weight = data[15:0];
			REG_POSITION_GATE: filt_cfg.position_gate = data[30:0];
			REG_YAW_GATE:      filt_cfg.yaw_gate = data[15:0];
			REG_AGREE_NEEDED:  filt_cfg.agree_count_needed = data[7:0];
			REG_CAND_POS_TOL:  filt_cfg.candidate_position_tolerance = data[30:0];
			REG_CAND_YAW_TOL:  filt_cfg.candidate_yaw_tolerance = data[15:0];
			default: ;
		endcase
	endfunction

	// floor((v + 2^15) / 2^16): round half toward plus infinity
	function automatic longint round_q16(longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	function automatic logic signed [31:0] blend_axis(logic signed [31:0] base,
			logic signed [31:0] meas, logic [15:0] w);
		longint d;
		d = longint'(meas) - longint'(base);
		return 32'(longint'(base) + round_q16(d * longint'(w)));
	endfunction

	// Shortest-arc heading difference, half a turn reads as -32768
	function automatic int yaw_arc(logic [15:0] meas, logic [15:0] base);
		logic signed [15:0] d;
		d = meas - base;
		return int'(d);
	endfunction

	function automatic logic [15:0] blend_heading(logic [15:0] base, logic [15:0] meas,
			logic [15:0] w);
		return 16'(longint'(base) + round_q16(longint'(yaw_arc(meas, base)) * longint'(w)));
	endfunction

	function automatic longint unsigned mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic bit dist_above(longint dx, longint dy, longint unsigned lim);
		longint unsigned ax, ay;
		ax = mag(dx);
		ay = mag(dy);
		if (ax > lim || ay > lim) return 1'b1;
		return ax * ax + ay * ay > lim * lim;
	endfunction

	function automatic bit dist_below(longint dx, longint dy, longint unsigned lim);
		longint unsigned ax, ay;
		ax = mag(dx);
		ay = mag(dy);
		if (ax >= lim || ay >= lim) return 1'b0;
		return ax * ax + ay * ay < lim * lim;
	endfunction

	function automatic result_t filter_step(meas_t m);
		result_t            r;
		logic signed [31:0] mx, my;
		logic [15:0]        myaw;
		bit                 outlier, agree;
		mx = m.meas_x;
		my = m.meas_y;
		myaw = m.meas_heading;
		if (!pose_locked) begin
			// first request after reset takes the pose as is
			pose_x = mx;
			pose_y = my;
			pose_yaw = myaw;
			pose_locked = 1'b1;
			cand_n = '0;
			r.outcome = OUT_LOCK;
		end else begin
			outlier = dist_above(longint'(mx) - longint'(pose_x),
					longint'(my) - longint'(pose_y), longint'(filt_cfg.position_gate)) ||
				mag(yaw_arc(myaw, pose_yaw)) > longint'(filt_cfg.yaw_gate);
			if (outlier) begin
				agree = cand_n != 0 &&
					dist_below(longint'(mx) - longint'(cand_x), longint'(my) - longint'(cand_y),
						longint'(filt_cfg.candidate_position_tolerance)) &&
					mag(yaw_arc(myaw, cand_yaw)) < longint'(filt_cfg.candidate_yaw_tolerance);
				if (agree) begin
					cand_x = blend_axis(cand_x, mx, 16'h8000);
					cand_y = blend_axis(cand_y, my, 16'h8000);
					cand_yaw = blend_heading(cand_yaw, myaw, 16'h8000);
					if (cand_n != COUNT_MAX) cand_n++;
				end else begin
					cand_x = mx;
					cand_y = my;
					cand_yaw = myaw;
					cand_n = 8'd1;
				end
				if (cand_n >= filt_cfg.agree_count_needed) begin
					pose_x = cand_x;
					pose_y = cand_y;
					pose_yaw = cand_yaw;
					cand_n = '0;
					r.outcome = OUT_RELOC;
				end else begin
					r.outcome = OUT_PENDING;
				end
			end else begin
				cand_n = '0;
				pose_x = blend_axis(pose_x, mx, filt_cfg.blend_weight);
				pose_y = blend_axis(pose_y, my, filt_cfg.blend_weight);
				pose_yaw = blend_heading(pose_yaw, myaw, filt_cfg.blend_weight);
				r.outcome = OUT_FILTER;
			end
		end
		r.pose_x = pose_x;
		r.pose_y = pose_y;
		r.pose_yaw = pose_yaw;
		r.pending_count = cand_n;
		return r;
	endfunction

	// ---------------- stimulus ----------------

	// Offsets wrap into the 32-bit and 16-bit fields
	function automatic meas_t place_meas(anchor_t at, longint dx, longint dy, int dyaw);
		meas_t  m;
		longint bx, by;
		int     byaw;
		case (at)
			AT_POSE: begin
				bx = pose_x;
				by = pose_y;
				byaw = pose_yaw;
			end
			AT_CAND: begin
				bx = cand_x;
				by = cand_y;
				byaw = cand_yaw;
			end
			default: begin
				bx = 0;
				by = 0;
				byaw = 0;
			end
		endcase
		m.meas_x = 32'(bx + dx);
		m.meas_y = 32'(by + dy);
		m.meas_heading = 16'(byaw + dyaw);
		return m;
	endfunction

	// Uniform in [-h, h]
	function automatic longint spread(longint h);
		return longint'($urandom_range(0, 32'(2 * h))) - h;
	endfunction

	function automatic meas_t next_meas();
		longint  g, t, dx, dy, sgn;
		int      yg, yt, dyaw, pick, total;
		anchor_t at;
		g = filt_cfg.position_gate;
		t = filt_cfg.candidate_position_tolerance;
		yg = (filt_cfg.yaw_gate > 16'd32768) ? 32768 : int'(filt_cfg.yaw_gate);
		yt = filt_cfg.candidate_yaw_tolerance;
		pick = $urandom_range(0, 99);
		sgn = ($urandom_range(0, 1) != 0) ? 64'sd1 : -64'sd1;
		dx = 0;
		dy = 0;
		dyaw = 0;
		at = AT_POSE;
		if (streak_left > 0 && (pick >= 8 || filt_cfg.agree_count_needed > 8'd32)) begin
			// next member of the cluster, close to the candidate
			streak_left--;
			at = AT_CAND;
			dx = ($urandom_range(0, 9) == 0) ? t * sgn : spread(t / 4);
			dy = spread(t / 4);
			dyaw = int'(spread(yt / 4));
		end else if (pick < 45) begin
			// inlier around the smoothed pose
			dx = spread(g / 2);
			dy = spread(g / 2);
			dyaw = int'(spread(yg / 2));
		end else if (pick < 72) begin
			// open a cluster of outliers away from the pose
			if (full_cluster_due || $urandom_range(0, 1) != 0) begin
				total = int'(filt_cfg.agree_count_needed) + $urandom_range(0, 2);
				full_cluster_due = 1'b0;
			end else begin
				total = $urandom_range(1, int'(filt_cfg.agree_count_needed) + 1);
			end
			streak_left = (total > 1) ? total - 1 : 0;
			if ($urandom_range(0, 2) == 0 && yg < 32768) begin
				dyaw = int'(sgn) * (yg + 1 + $urandom_range(0, 32767 - yg));
			end else begin
				dx = sgn * (g + 1 + 4 * t + longint'($urandom_range(0, 65535)));
				dy = spread(g / 4);
			end
		end else if (pick < 88) begin
			// right on a gate or one past it
			case ($urandom_range(0, 3))
				0: dx = g * sgn;
				1: dy = (g + 1) * sgn;
				2: dyaw = int'(sgn) * yg;
				default: dyaw = int'(sgn) * (yg + 1);
			endcase
		end else begin
			// raw noise over the whole field range
			at = AT_ABS;
			dx = longint'(int'($urandom));
			dy = longint'(int'($urandom));
			dyaw = $urandom_range(0, 65535);
		end
		return place_meas(at, dx, dy, dyaw);
	endfunction

	task automatic add_row(anchor_t at, longint dx, longint dy, int dyaw, bit checked = 1'b0,
			outcome_t oc = OUT_LOCK, longint x = 0, longint y = 0, int yaw = 0, int n = 0);
		dir_row_t r;
		r.anchor = at;
		r.dx = dx;
		r.dy = dy;
		r.dyaw = dyaw;
		r.checked = checked;
		r.outcome = oc;
		r.x = x;
		r.y = y;
		r.yaw = yaw;
		r.count = n;
		dir_rows.push_back(r);
	endtask

	// Push one request; on acceptance queue the pose report it must produce
	task automatic send_meas(meas_t m, bit typed, result_t want);
		int      gap;
		result_t predicted;
		gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= m;
		@(posedge clk);
		while (full) @(posedge clk);
		predicted = filter_step(m);
		pose_reports_due.push_back(typed ? want : predicted);
	endtask

	// Leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		filter_config(idx, data);
	endtask

	// Random bits above the register width must be ignored
	function automatic logic [31:0] with_junk(logic [31:0] value, int width);
		logic [31:0] junk;
		junk = $urandom;
		return value | (junk << width);
	endfunction

	task automatic load_phase_regs(int phase);
		logic [31:0] v [6];
		case (phase)
			PH_WIDE: v = '{32'hFFFF, 32'h7FFF_FFFF, 32'hFFFF, 32'd255, 32'h7FFF_FFFF, 32'd32768};
			PH_NARROW: v = '{default: 32'd0};
			PH_LONG_STREAK: v = '{$urandom_range(0, 65535), 32'd26214, 32'd5215, 32'd255,
				32'd80000, 32'd4000};
			default: begin
				v[0] = $urandom_range(0, 65535);
				v[1] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32'h7FFF_FFFF) :
					$urandom_range(0, 200000);
				v[2] = ($urandom_range(0, 7) == 0) ? $urandom_range(32769, 65535) :
					$urandom_range(0, 32768);
				v[3] = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 12);
				v[4] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32'h7FFF_FFFF) :
					$urandom_range(0, 100000);
				v[5] = $urandom_range(0, 32768);
			end
		endcase
		write_reg(REG_BLEND_WEIGHT, with_junk(v[0], 16));
		write_reg(REG_POSITION_GATE, with_junk(v[1], 31));
		write_reg(REG_YAW_GATE, with_junk(v[2], 16));
		write_reg(REG_AGREE_NEEDED, with_junk(v[3], 8));
		write_reg(REG_CAND_POS_TOL, with_junk(v[4], 31));
		write_reg(REG_CAND_YAW_TOL, with_junk(v[5], 16));
		write_reg(CFG_IDX_W'($urandom_range(REG_CAND_YAW_TOL + 1, 255)), $urandom);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pose_reports_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ---------------- checking ----------------

	task automatic check_report(result_t want, result_t seen);
		if (seen.outcome !== want.outcome) begin
			errors++;
			$error("outcome: expected %0d, got %0d", want.outcome, seen.outcome);
		end
		if (seen.pose_x !== want.pose_x) begin
			errors++;
			$error("pose_x: expected %0d, got %0d", $signed(want.pose_x), $signed(seen.pose_x));
		end
		if (seen.pose_y !== want.pose_y) begin
			errors++;
			$error("pose_y: expected %0d, got %0d", $signed(want.pose_y), $signed(seen.pose_y));
		end
		if (seen.pose_yaw !== want.pose_yaw) begin
			errors++;
			$error("pose_yaw: expected %0d, got %0d", want.pose_yaw, seen.pose_yaw);
		end
		if (seen.pending_count !== want.pending_count) begin
			errors++;
			$error("pending_count: expected %0d, got %0d", want.pending_count,
				seen.pending_count);
		end
	endtask

	// Result side: pop with random stalls, compare against the oldest report due
	initial begin
		int      gap;
		result_t seen;
		@(posedge arst_n);
		forever begin
			gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			seen = result;
			if (pose_reports_due.size() == 0) begin
				errors++;
				$error("pose report with none due: outcome %0d", seen.outcome);
			end else begin
				check_report(pose_reports_due.pop_front(), seen);
			end
		end
	end

	// ---------------- main sequence ----------------

	initial begin
		dir_row_t row;
		result_t  want;
		int       budget;
		filter_reset();
		want = '0;

		// lock on the extremes, then hold still
		add_row(AT_ABS, POS_MIN, POS_MAX, 16'hFFFF, 1, OUT_LOCK, POS_MIN, POS_MAX, 16'hFFFF, 0);
		add_row(AT_POSE, 0, 0, 0, 1, OUT_FILTER, POS_MIN, POS_MAX, 16'hFFFF, 0);
		// opposite extremes: outlier cluster that relocalizes at the default count
		add_row(AT_ABS, POS_MAX, POS_MIN, 16'h7FFF, 1, OUT_PENDING, POS_MIN, POS_MAX, 16'hFFFF, 1);
		add_row(AT_CAND, 0, 0, 0, 1, OUT_PENDING, POS_MIN, POS_MAX, 16'hFFFF, 2);
		add_row(AT_CAND, 0, 0, 0, 1, OUT_PENDING, POS_MIN, POS_MAX, 16'hFFFF, 3);
		add_row(AT_CAND, 0, 0, 0, 1, OUT_PENDING, POS_MIN, POS_MAX, 16'hFFFF, 4);
		add_row(AT_CAND, 0, 0, 0, 1, OUT_RELOC, POS_MAX, POS_MIN, 16'h7FFF, 0);
		// exactly on the position gate, then one past it
		add_row(AT_POSE, -26214, 0, 0);
		add_row(AT_POSE, 0, 26215, 0);
		// exactly on the yaw gate, one past it, then half a turn
		add_row(AT_POSE, 0, 0, 5215);
		add_row(AT_POSE, 0, 0, -5216);
		add_row(AT_POSE, 0, 0, -32768);
		// candidate tolerances: equal never agrees, just under does
		add_row(AT_CAND, -9830, 0, 0);
		add_row(AT_CAND, 0, 0, 2086);
		add_row(AT_CAND, 0, 0, 2085);
		add_row(AT_CAND, -6950, 6950, 0);
		add_row(AT_CAND, 6951, 6951, -1);
		// diagonal: each axis inside the gate, norm just outside / inside
		add_row(AT_POSE, -18537, 18537, 0);
		add_row(AT_POSE, -18535, 18535, 0);
		// all-zero request, then a cluster with odd averages
		add_row(AT_ABS, 0, 0, 0);
		add_row(AT_CAND, 1, -1, 1);
		add_row(AT_CAND, 1, -1, 1);
		add_row(AT_CAND, 1, -1, 1);
		add_row(AT_CAND, 1, -1, 1);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			want.outcome = row.outcome;
			want.pose_x = 32'(row.x);
			want.pose_y = 32'(row.y);
			want.pose_yaw = 16'(row.yaw);
			want.pending_count = 8'(row.count);
			send_meas(place_meas(row.anchor, row.dx, row.dy, row.dyaw), row.checked, want);
		end
		push <= 1'b0;
		wait_drained();

		// random phases, registers rewritten while the filter is idle
		for (int phase = 1; phase <= PHASES; phase++) begin
			load_phase_regs(phase);
			tx_idle = (phase % 3) != 0;
			rx_idle = (phase % 4) != 1;
			streak_left = 0;
			full_cluster_due = 1'b1;
			budget = PHASE_ITEMS;
			while (budget > 0 || streak_left > 0) begin
				send_meas(next_meas(), 1'b0, want);
				budget--;
			end
			push <= 1'b0;
			wait_drained();
		end

		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
